// ===== hdl/fqkr_pkg.sv =====
// Shared types and constants for the keyed-removal FIFO queue.
// No dependencies; imported by the controller, datapath and top level.
package fqkr_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  localparam int CMD_W = 2;
  localparam int ID_W  = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted item, clear result flags
    logic push_write;   // append at the tail or flag full
    logic start_read;   // read the head entry, reset scan index
    logic pop_take;     // take read data as popped entry, advance head
    logic advance;      // read the next entry of the scan
    logic mark_hole;    // remember the matching slot
    logic shift_write;  // move read data into the hole
    logic remove_done;  // drop one entry, flag found
    logic load_out;     // move result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_remove;
    logic empty;
    logic match;
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/fqkr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqkr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== hdl/fqkr_ctrl.sv =====
// Sequencing state machine for the keyed-removal FIFO queue.
// Depends on fqkr_pkg.
module fqkr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fqkr_pkg::dp_sts_t sts,
  output fqkr_pkg::dp_cmd_t cmd
);
  import fqkr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_POP    = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_push) begin
          cmd.push_write = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.is_pop && !sts.empty) begin
          cmd.start_read = 1'b1;
          state_nxt      = S_POP;
        end else if (sts.is_remove && !sts.empty) begin
          cmd.start_read = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        priority if (sts.match && sts.last) begin
          cmd.remove_done = 1'b1;
          state_nxt       = S_DONE;
        end else if (sts.match) begin
          cmd.mark_hole = 1'b1;
          cmd.advance   = 1'b1;
          state_nxt     = S_SHIFT;
        end else if (sts.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_write = 1'b1;
        if (sts.last) begin
          cmd.remove_done = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/fqkr_dp.sv =====
// Datapath of the keyed-removal FIFO queue: circular entry store, pointers,
// scan index, result flags and output register. Depends on fqkr_pkg, fqkr_ram.
module fqkr_dp #(
  parameter int DEPTH   = fqkr_pkg::DEPTH_DEF,
  parameter int ID_BITS = fqkr_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fqkr_pkg::CMD_W-1:0]  in_cmd,
  input  logic [fqkr_pkg::ID_W-1:0]   in_conn_id,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [fqkr_pkg::ID_W-1:0]   out_popped_id,
  output logic                        out_popped_valid,
  output logic                        out_removed_found,
  output logic                        out_full_error,
  output logic                        out_is_empty,
  input  fqkr_pkg::dp_cmd_t           cmd,
  output fqkr_pkg::dp_sts_t           sts
);
  import fqkr_pkg::*;

  localparam int PW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int KEEP_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  logic [PW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [PW-1:0]      addr_r, addr_nxt;
  logic [PW-1:0]      hole_r, hole_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [ID_W-1:0]    pid_r, pid_nxt;
  logic               pv_r, pv_nxt;
  logic               found_r, found_nxt;
  logic               full_r, full_nxt;
  logic               ov_r, ov_nxt;
  logic [ID_W-1:0]    o_pid_r, o_pid_nxt;
  logic               o_pv_r, o_pv_nxt;
  logic               o_found_r, o_found_nxt;
  logic               o_full_r, o_full_nxt;
  logic               o_empty_r, o_empty_nxt;

  logic               we, re;
  logic [PW-1:0]      wa, ra;
  logic [ID_BITS-1:0] wd, rd;
  logic [PW:0]        tail_sum;
  logic [PW-1:0]      tail;
  logic [PW-1:0]      addr_inc, head_inc;
  logic [CW-1:0]      idx_inc;

  fqkr_ram #(.WIDTH(ID_BITS), .DEPTH(DEPTH)) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .re  (re),
    .ra  (ra),
    .rd  (rd)
  );

  // Tail slot: head plus count, wrapped once
  assign tail_sum = (PW + 1)'(head_r) + (PW + 1)'(cnt_r);
  assign tail     = (tail_sum >= (PW + 1)'(DEPTH)) ? PW'(tail_sum - (PW + 1)'(DEPTH))
                                                   : PW'(tail_sum);
  assign addr_inc = (addr_r == PW'(DEPTH - 1)) ? '0 : addr_r + 1'b1;
  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign idx_inc  = idx_r + 1'b1;

  assign sts.is_push   = (cmd_r == CMD_PUSH);
  assign sts.is_pop    = (cmd_r == CMD_POP);
  assign sts.is_remove = (cmd_r == CMD_REMOVE);
  assign sts.empty     = (cnt_r == '0);
  assign sts.match     = (rd == id_r);
  assign sts.last      = (idx_inc == cnt_r);
  assign sts.out_free  = !ov_r || !out_stall;

  always_comb begin
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    addr_nxt    = addr_r;
    hole_nxt    = hole_r;
    idx_nxt     = idx_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    pid_nxt     = pid_r;
    pv_nxt      = pv_r;
    found_nxt   = found_r;
    full_nxt    = full_r;
    ov_nxt      = ov_r;
    o_pid_nxt   = o_pid_r;
    o_pv_nxt    = o_pv_r;
    o_found_nxt = o_found_r;
    o_full_nxt  = o_full_r;
    o_empty_nxt = o_empty_r;
    we          = 1'b0;
    wa          = tail;
    wd          = id_r;
    re          = 1'b0;
    ra          = head_r;

    if (cmd.capture) begin
      cmd_nxt   = in_cmd;
      id_nxt    = ID_BITS'(in_conn_id[KEEP_BITS-1:0]);
      pid_nxt   = '0;
      pv_nxt    = 1'b0;
      found_nxt = 1'b0;
      full_nxt  = 1'b0;
    end
    if (cmd.push_write) begin
      if (cnt_r == CW'(DEPTH)) begin
        full_nxt = 1'b1;
      end else begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.start_read) begin
      re       = 1'b1;
      addr_nxt = head_r;
      idx_nxt  = '0;
    end
    if (cmd.pop_take) begin
      pid_nxt  = ID_W'(rd);
      pv_nxt   = 1'b1;
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (cmd.mark_hole) begin
      hole_nxt = addr_r;
    end
    if (cmd.shift_write) begin
      we       = 1'b1;
      wa       = hole_r;
      wd       = rd;
      hole_nxt = addr_r;
    end
    if (cmd.advance) begin
      re       = 1'b1;
      ra       = addr_inc;
      addr_nxt = addr_inc;
      idx_nxt  = idx_inc;
    end
    if (cmd.remove_done) begin
      found_nxt = 1'b1;
      cnt_nxt   = cnt_r - 1'b1;
    end
    if (cmd.load_out) begin
      ov_nxt      = 1'b1;
      o_pid_nxt   = pid_r;
      o_pv_nxt    = pv_r;
      o_found_nxt = found_r;
      o_full_nxt  = full_r;
      o_empty_nxt = (cnt_r == '0);
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    hole_r    <= hole_nxt;
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    pid_r     <= pid_nxt;
    pv_r      <= pv_nxt;
    found_r   <= found_nxt;
    full_r    <= full_nxt;
    o_pid_r   <= o_pid_nxt;
    o_pv_r    <= o_pv_nxt;
    o_found_r <= o_found_nxt;
    o_full_r  <= o_full_nxt;
    o_empty_r <= o_empty_nxt;
  end

  assign out_valid         = ov_r;
  assign out_popped_id     = o_pid_r;
  assign out_popped_valid  = o_pv_r;
  assign out_removed_found = o_found_r;
  assign out_full_error    = o_full_r;
  assign out_is_empty      = o_empty_r;

endmodule

// ===== hdl/fifo_queue_with_keyed_removal_core.sv =====
// Top level of the keyed-removal FIFO queue of connection identifiers.
// Depends on fqkr_pkg, fqkr_ctrl, fqkr_dp (which holds the fqkr_ram store).
// Usage:
//   Input channel (in_valid / in_stall, in_cmd, in_conn_id) carries one
//   command per item: push, pop, or remove-by-value. Unused codes do nothing.
//   Result channel (out_valid / out_stall) returns exactly one result item
//   per input item, in order: popped identifier and flag, remove-found flag,
//   full-error flag and the empty flag after the step.
//   Entries live in a circular RAM (head pointer plus count). Remove scans
//   from the head one entry per cycle and, on a match, moves every later
//   entry down one slot, one per cycle, through the single RAM write port.
// Push, or a command with nothing to do, is the shortest item; pop adds a head
//   read, and remove takes longer the more entries it scans, up to DEPTH of them.
//   One item is in work at a time; in_stall is high from the cycle after
//   accept until the result is loaded, so the remove scan sets the rate.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; RAM contents are not cleared, as only occupied slots are read.
// A stalled result holds in the output register; the block waits with the
// next result until that one is taken, then accepts again.
module fifo_queue_with_keyed_removal_core #(
  parameter int DEPTH   = fqkr_pkg::DEPTH_DEF,
  parameter int ID_BITS = fqkr_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fqkr_pkg::CMD_W-1:0] in_cmd,
  input  logic [fqkr_pkg::ID_W-1:0]  in_conn_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fqkr_pkg::ID_W-1:0]  out_popped_id,
  output logic                       out_popped_valid,
  output logic                       out_removed_found,
  output logic                       out_full_error,
  output logic                       out_is_empty
);
  import fqkr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: accepts only when idle, steps the datapath through the command
  fqkr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, pointers, scan logic and output register
  fqkr_dp #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_conn_id        (in_conn_id),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_popped_id     (out_popped_id),
    .out_popped_valid  (out_popped_valid),
    .out_removed_found (out_removed_found),
    .out_full_error    (out_full_error),
    .out_is_empty      (out_is_empty),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ===== hdl/fqkr_checker.sv =====
// Port-level assertions for the keyed-removal FIFO queue, bound to the top.
// Depends on fqkr_pkg and fifo_queue_with_keyed_removal_core.
module fqkr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [fqkr_pkg::ID_W-1:0]  out_popped_id,
  input logic                       out_popped_valid,
  input logic                       out_removed_found,
  input logic                       out_full_error,
  input logic                       out_is_empty
);

  // One item in work at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous item still in work");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_popped_id)
      && $stable(out_popped_valid) && $stable(out_removed_found)
      && $stable(out_full_error) && $stable(out_is_empty)))
    else $error("stalled result changed");

  // At most one outcome flag per result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_popped_valid, out_removed_found, out_full_error}))
    else $error("more than one outcome flag set");

  // Identifier is zero unless a pop returned an entry
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_popped_valid) |-> (out_popped_id == '0))
    else $error("popped identifier nonzero without pop");

  // A dropped push means the queue was full, so it cannot be empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_error) |-> !out_is_empty)
    else $error("full error reported with empty queue");

endmodule

bind fifo_queue_with_keyed_removal_core fqkr_checker u_fqkr_checker (.*);
